// ----- hdl/bms_pkg.sv -----
// Shared types and constants for the Bezier midpoint subdivision block.
// No dependencies; imported by bms_mid, bms_store and the top level.
`default_nettype none

package bms_pkg;

    // Width of one Q16.16 coordinate
    localparam int COORD_W = 32;

    // One control point, x in the low half, y in the high half
    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

endpackage

`default_nettype wire

// ----- hdl/bms_mid.sv -----
// Shared midpoint unit: floor((a + b) / 2) on both coordinates of two points.
// Depends on bms_pkg for the point type.
`default_nettype none

module bms_mid (
    input  bms_pkg::t_point i_a,
    input  bms_pkg::t_point i_b,
    output bms_pkg::t_point o_mid
);
    import bms_pkg::*;

    logic signed [COORD_W:0] sum_x;
    logic signed [COORD_W:0] sum_y;

    // Add in one extra bit so the sum is exact, then drop the low bit
    assign sum_x = {i_a.x[COORD_W-1], i_a.x} + {i_b.x[COORD_W-1], i_b.x};
    assign sum_y = {i_a.y[COORD_W-1], i_a.y} + {i_b.y[COORD_W-1], i_b.y};

    assign o_mid.x = sum_x[COORD_W:1];
    assign o_mid.y = sum_y[COORD_W:1];

endmodule

`default_nettype wire

// ----- hdl/bms_store.sv -----
// Control point memory: one write port, one read port with registered data.
// Depends on bms_pkg for the point type.
`default_nettype none

module bms_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire             i_clk,
    input  wire             i_we,
    input  wire  [AW-1:0]   i_waddr,
    input  bms_pkg::t_point i_wdata,
    input  wire  [AW-1:0]   i_raddr,
    output bms_pkg::t_point o_rdata
);
    import bms_pkg::*;

    t_point r_mem [0:DEPTH-1];
    t_point r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/bezier_midpoint_subdivide_top.sv -----
// Bezier curve subdivision at t = 1/2 by de Casteljau averaging, Q16.16.
// Depends on bms_pkg, bms_store and bms_mid.
//
// Control points arrive one per item; tlast marks the final point and starts
// the split. After the final point the block drops ready and works the curve
// in place in a memory with one write and one read port, using one midpoint
// unit: per level it fetches the head point and emits it as a left point,
// then reads each neighbour and writes back each midpoint in turn. After the
// last level it reads out the right-half points in order. For n stored points
// the results are n left points (tuser[0] = 0) then n right points
// (tuser[0] = 1, tlast on the final one). Points beyond MAX_POINTS are
// dropped and tuser[1] is set on every result of that curve. A single-point
// curve returns that point once in each half.
`default_nettype none

module bezier_midpoint_subdivide_top #(
    parameter int MAX_POINTS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input points
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] point_x, [63:32] point_y
    input  wire         s_axis_tlast,   // last_point
    // Result points
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_x, [63:32] out_y
    output logic [1:0]  m_axis_tuser,   // [0] which_half, [1] overflowed
    output logic        m_axis_tlast    // last_result
);
    import bms_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LRD   = 3'd1;
    localparam logic [2:0] S_LCAP  = 3'd2;
    localparam logic [2:0] S_LEMIT = 3'd3;
    localparam logic [2:0] S_SRD   = 3'd4;
    localparam logic [2:0] S_SEX   = 3'd5;
    localparam logic [2:0] S_RRD   = 3'd6;
    localparam logic [2:0] S_REMIT = 3'd7;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_lvl, n_lvl;
    logic [AW-1:0] r_idx, n_idx;
    t_point        r_prev, n_prev;

    logic          r_out_valid, n_out_valid;
    t_point        r_out, n_out;
    logic          r_out_half, n_out_half;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          in_acc;
    logic          out_free;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_point        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_point        mem_rdata;
    t_point        in_pt;
    t_point        mid_pt;
    logic [CW:0]   cnt_ext;
    logic [CW:0]   lvl_ext;
    logic [CW:0]   idx_ext;
    logic          more_steps;
    logic          level_done;
    logic          right_done;

    bms_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bms_mid u_mid (
        .i_a   (r_prev),
        .i_b   (mem_rdata),
        .o_mid (mid_pt)
    );

    assign in_pt.x = s_axis_tdata[31:0];
    assign in_pt.y = s_axis_tdata[63:32];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Loop bounds: level L has n-1-L midpoints
    assign cnt_ext    = (CW+1)'(r_count);
    assign lvl_ext    = (CW+1)'(r_lvl);
    assign idx_ext    = (CW+1)'(r_idx);
    assign more_steps = (lvl_ext + (CW+1)'(1)) < cnt_ext;
    assign level_done = (idx_ext + lvl_ext + (CW+1)'(2)) == cnt_ext;
    assign right_done = (idx_ext + (CW+1)'(1)) == cnt_ext;

    // Memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        mem_wdata = in_pt;
        mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                mem_we = in_acc && (r_count < CW'(MAX_POINTS));
            end
            S_SRD: begin
                mem_raddr = r_idx + AW'(1);
            end
            S_SEX: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = mid_pt;
            end
            S_RRD, S_REMIT: begin
                mem_raddr = r_idx;
            end
            default: begin
                mem_raddr = '0;
            end
        endcase
    end

    // Sequencer and output stage
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_lvl       = r_lvl;
        n_idx       = r_idx;
        n_prev      = r_prev;
        n_out       = r_out;
        n_out_half  = r_out_half;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_lvl   = '0;
                        n_state = S_LRD;
                    end
                end
            end
            S_LRD: begin
                n_state = S_LCAP;
            end
            S_LCAP: begin
                n_prev  = mem_rdata;
                n_state = S_LEMIT;
            end
            S_LEMIT: begin
                // Emit the head of the current level as a left point
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_prev;
                    n_out_half  = 1'b0;
                    n_out_last  = 1'b0;
                    n_out_ovf   = r_ovf;
                    n_idx       = '0;
                    n_state     = more_steps ? S_SRD : S_RRD;
                end
            end
            S_SRD: begin
                n_state = S_SEX;
            end
            S_SEX: begin
                // Average neighbours, keep the right one for the next step
                n_prev = mem_rdata;
                if (level_done) begin
                    n_lvl   = r_lvl + AW'(1);
                    n_state = S_LRD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SRD;
                end
            end
            S_RRD: begin
                n_state = S_REMIT;
            end
            S_REMIT: begin
                // The finished array holds the right half in order
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mem_rdata;
                    n_out_half  = 1'b1;
                    n_out_last  = right_done;
                    n_out_ovf   = r_ovf;
                    if (right_done) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_out      <= n_out;
        r_out_half <= n_out_half;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.y, r_out.x};
    assign m_axis_tuser  = {r_out_ovf, r_out_half};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/bms_chk.sv -----
// Port-level checks for the Bezier midpoint subdivision block, bound to the top.
// Depends only on the top level's ports.
`default_nettype none

module bms_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser,
    input wire        m_axis_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // The final point of a curve starts the split and closes the input
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after final point");

    // A point that is not the last produces no result
    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast && !m_axis_tvalid
            |=> !m_axis_tvalid)
        else $error("result after a non-final point");

    // The closing result belongs to the right half
    a_last_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("tlast on a left-half point");

    // The input stays closed while a left-half result is on the output
    a_closed_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !s_axis_tready)
        else $error("input open during left half");

endmodule

bind bezier_midpoint_subdivide_top bms_chk u_bms_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
